// File: rtl/core/tcch_pkg.sv
// ----------------------------------------------------------------------------
// tcch_pkg: shared types and constants for the compass heading block
// Beat layout, queue sizing, CORDIC angle table and turn constants.
// ----------------------------------------------------------------------------
`default_nettype none

package tcch_pkg;

	localparam int ISQ_STEPS    = 20;   // root bits, one per stage
	localparam int CORDIC_STEPS = 20;
	localparam int NSTG         = 50;   // back stages ahead of the output register
	localparam int FIFO_DEPTH   = 4;
	localparam int FIFO_AW      = 2;

	localparam logic [12:0] OFFSET_RESET = 13'd176;   // 11 degrees
	localparam logic [14:0] TURN_16THS   = 15'd5760;

	// angles in 1/65536 degree
	localparam logic signed [26:0] FULL_TURN    = 27'sd23592960;
	localparam logic signed [26:0] HALF_TURN    = 27'sd11796480;
	localparam logic signed [26:0] QUARTER_TURN = 27'sd5898240;

	typedef struct packed {
		logic               bad;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic signed [15:0] mx;
		logic signed [15:0] my;
		logic signed [15:0] mz;
	} item_t;

	// atan(2^-i) in 1/65536 degree
	function automatic logic signed [25:0] atan_lut(input logic [4:0] i);
		logic signed [25:0] v;
		begin
			case (i)
				5'd0:  v = 26'sd2949120;
				5'd1:  v = 26'sd1740967;
				5'd2:  v = 26'sd919879;
				5'd3:  v = 26'sd466945;
				5'd4:  v = 26'sd234379;
				5'd5:  v = 26'sd117304;
				5'd6:  v = 26'sd58666;
				5'd7:  v = 26'sd29335;
				5'd8:  v = 26'sd14668;
				5'd9:  v = 26'sd7334;
				5'd10: v = 26'sd3667;
				5'd11: v = 26'sd1833;
				5'd12: v = 26'sd917;
				5'd13: v = 26'sd458;
				5'd14: v = 26'sd229;
				5'd15: v = 26'sd115;
				5'd16: v = 26'sd57;
				5'd17: v = 26'sd29;
				5'd18: v = 26'sd14;
				5'd19: v = 26'sd7;
				default: v = 26'sd0;
			endcase
			return v;
		end
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/tcch_front.sv
// ----------------------------------------------------------------------------
// tcch_front: input classifier
// Flags a zero accelerometer and scales the accel vector so its largest
// magnitude lands in 2^14..2^15.
// ----------------------------------------------------------------------------
`default_nettype none

module tcch_front (
	input  tcch_pkg::item_t raw,
	output tcch_pkg::item_t cls
);

	logic [16:0] max_x, max_y, max_z, amax;
	logic [3:0]  shamt;

	function automatic logic [16:0] mag16(input logic [15:0] v);
		return v[15] ? (17'd0 - {1'b1, v}) : {1'b0, v};
	endfunction

	always_comb begin
		max_x = mag16(raw.ax);
		max_y = mag16(raw.ay);
		max_z = mag16(raw.az);
		amax  = max_x;
		if (max_y > amax) amax = max_y;
		if (max_z > amax) amax = max_z;
		// left shift that brings the top set bit to bit 14
		shamt = 4'd0;
		for (int i = 0; i < 14; i++) begin
			if (amax[i]) shamt = 4'(14 - i);
		end
		if (amax[16:14] != 3'd0) shamt = 4'd0;
	end

	always_comb begin
		cls     = raw;
		cls.bad = (amax == 17'd0);
		cls.ax  = raw.ax <<< shamt;
		cls.ay  = raw.ay <<< shamt;
		cls.az  = raw.az <<< shamt;
	end

endmodule

`default_nettype wire

// File: rtl/core/tcch_fifo.sv
// ----------------------------------------------------------------------------
// tcch_fifo: short item queue
// Register queue between the classifier and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module tcch_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tcch_pkg::item_t wdata,
	output logic            full,
	input  logic            pop,
	output logic            nonempty,
	output tcch_pkg::item_t rdata
);

	tcch_pkg::item_t                mem_q [0:tcch_pkg::FIFO_DEPTH-1];
	logic [tcch_pkg::FIFO_AW-1:0]   wr_q, rd_q;
	logic [tcch_pkg::FIFO_AW:0]     cnt_q;

	assign full     = (cnt_q == (tcch_pkg::FIFO_AW+1)'(tcch_pkg::FIFO_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign rdata    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/tcch_back.sv
// ----------------------------------------------------------------------------
// tcch_back: heading datapath
// Squares, pipelined roots, tilt products, normalize, CORDIC, placement.
// ----------------------------------------------------------------------------
`default_nettype none

module tcch_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  tcch_pkg::item_t in_item,
	output logic            in_pop,
	input  logic [12:0]     offset,
	output logic            m_valid,
	input  logic            m_ready,
	output logic [12:0]     m_heading,
	output logic            m_invalid
);

	typedef struct packed {
		logic               bad;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] mx;
		logic signed [15:0] my;
		logic signed [15:0] mz;
	} car_t;

	typedef struct packed {
		logic bad;
		logic swp;      // |Y| > |X|
		logic xneg;
		logic ypos;
		logic small0;
	} flg_t;

	logic                      adv;
	logic [tcch_pkg::NSTG-1:0] vld_q;
	logic                      out_vld_q;

	assign adv     = !out_vld_q || m_ready;
	assign in_pop  = adv && in_valid;
	assign m_valid = out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_q     <= {vld_q[tcch_pkg::NSTG-2:0], in_valid};
			out_vld_q <= vld_q[tcch_pkg::NSTG-1];
		end
	end

	// ---- s1: squares
	logic signed [31:0] pax_w, pay_w, paz_w;
	car_t               car_s1;
	logic [30:0]        ax2_s1, ay2_s1, az2_s1;

	assign pax_w = in_item.ax * in_item.ax;
	assign pay_w = in_item.ay * in_item.ay;
	assign paz_w = in_item.az * in_item.az;

	always_ff @(posedge clk) begin
		if (adv) begin
			car_s1 <= '{bad: in_item.bad, ax: in_item.ax, ay: in_item.ay,
				mx: in_item.mx, my: in_item.my, mz: in_item.mz};
			ax2_s1 <= pax_w[30:0];
			ay2_s1 <= pay_w[30:0];
			az2_s1 <= paz_w[30:0];
		end
	end

	// ---- s2: root operands at scale 256 (lane 0: pitch, 1: roll, 2: norm)
	car_t        car_s2;
	logic [39:0] v_s2 [0:2];

	always_ff @(posedge clk) begin
		if (adv) begin
			car_s2  <= car_s1;
			v_s2[0] <= {({1'b0, ay2_s1} + {1'b0, az2_s1}), 8'd0};
			v_s2[1] <= {({1'b0, ax2_s1} + {1'b0, az2_s1}), 8'd0};
			v_s2[2] <= {({1'b0, ax2_s1} + {1'b0, ay2_s1} + {1'b0, az2_s1}), 8'd0};
		end
	end

	// ---- s3..s22: restoring square root, one bit per stage
	car_t        isq_car_s  [0:tcch_pkg::ISQ_STEPS-1];
	logic [39:0] isq_v_s    [0:2][0:tcch_pkg::ISQ_STEPS-1];
	logic [21:0] isq_rem_s  [0:2][0:tcch_pkg::ISQ_STEPS-1];
	logic [19:0] isq_root_s [0:2][0:tcch_pkg::ISQ_STEPS-1];

	for (genvar g = 0; g < tcch_pkg::ISQ_STEPS; g++) begin : g_isq
		if (g == 0) begin : g_first
			always_ff @(posedge clk) if (adv) isq_car_s[g] <= car_s2;
		end else begin : g_next
			always_ff @(posedge clk) if (adv) isq_car_s[g] <= isq_car_s[g-1];
		end
		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [39:0] v_in;
			logic [21:0] r_in;
			logic [19:0] q_in;
			logic [23:0] rt;
			logic [23:0] tt;
			if (g == 0) begin : g_src0
				assign v_in = v_s2[l];
				assign r_in = '0;
				assign q_in = '0;
			end else begin : g_srcn
				assign v_in = isq_v_s[l][g-1];
				assign r_in = isq_rem_s[l][g-1];
				assign q_in = isq_root_s[l][g-1];
			end
			assign rt = {r_in, v_in[39:38]};
			assign tt = {2'b00, q_in, 2'b01};
			always_ff @(posedge clk) begin
				if (adv) begin
					isq_v_s[l][g] <= {v_in[37:0], 2'b00};
					if (rt >= tt) begin
						isq_rem_s[l][g]  <= 22'(rt - tt);
						isq_root_s[l][g] <= {q_in[18:0], 1'b1};
					end else begin
						isq_rem_s[l][g]  <= rt[21:0];
						isq_root_s[l][g] <= {q_in[18:0], 1'b0};
					end
				end
			end
		end
	end

	car_t        car_r;
	logic [19:0] qp_r, qr_r, n_r;
	assign car_r = isq_car_s[tcch_pkg::ISQ_STEPS-1];
	assign qp_r  = isq_root_s[0][tcch_pkg::ISQ_STEPS-1];
	assign qr_r  = isq_root_s[1][tcch_pkg::ISQ_STEPS-1];
	assign n_r   = isq_root_s[2][tcch_pkg::ISQ_STEPS-1];

	// ---- s23: first products
	logic signed [36:0] mq_w, yr_w;
	logic signed [31:0] za_w, ya_w, zy_w;
	logic signed [36:0] mq_s23, yr_s23;
	logic signed [31:0] za_s23, ya_s23, zy_s23;
	logic signed [15:0] mx_s23;
	logic [19:0]        n_s23, qp_s23;
	logic               bad_s23;

	assign mq_w = car_r.mx * $signed({1'b0, qp_r});
	assign yr_w = car_r.my * $signed({1'b0, qr_r});
	assign za_w = car_r.mz * car_r.ax;
	assign ya_w = car_r.ay * car_r.ax;
	assign zy_w = car_r.mz * car_r.ay;

	always_ff @(posedge clk) begin
		if (adv) begin
			mq_s23  <= mq_w;
			yr_s23  <= yr_w;
			za_s23  <= za_w;
			ya_s23  <= ya_w;
			zy_s23  <= zy_w;
			mx_s23  <= car_r.mx;
			n_s23   <= n_r;
			qp_s23  <= qp_r;
			bad_s23 <= car_r.bad;
		end
	end

	// ---- s24: X inner sum, Y partial products
	logic signed [37:0] sx_w;
	logic signed [31:0] y1h_w;
	logic signed [32:0] y1l_w, y3h_w;
	logic signed [37:0] y2h_w;
	logic signed [41:0] y2l_w, y3l_w;
	logic signed [37:0] sx_s24;
	logic signed [31:0] y1h_s24;
	logic signed [32:0] y1l_s24, y3h_s24;
	logic signed [37:0] y2h_s24;
	logic signed [41:0] y2l_s24, y3l_s24;
	logic [19:0]        n_s24;
	logic               bad_s24;

	assign sx_w  = 38'(mq_s23) + (38'(za_s23) <<< 4);
	assign y1h_w = mx_s23 * $signed(ya_s23[31:16]);
	assign y1l_w = mx_s23 * $signed({1'b0, ya_s23[15:0]});
	assign y2h_w = $signed(yr_s23[36:20]) * $signed({1'b0, n_s23});
	assign y2l_w = $signed({1'b0, yr_s23[19:0]}) * $signed({1'b0, n_s23});
	assign y3h_w = $signed(zy_s23[31:20]) * $signed({1'b0, qp_s23});
	assign y3l_w = $signed({1'b0, zy_s23[19:0]}) * $signed({1'b0, qp_s23});

	always_ff @(posedge clk) begin
		if (adv) begin
			sx_s24  <= sx_w;
			y1h_s24 <= y1h_w;
			y1l_s24 <= y1l_w;
			y2h_s24 <= y2h_w;
			y2l_s24 <= y2l_w;
			y3h_s24 <= y3h_w;
			y3l_s24 <= y3l_w;
			n_s24   <= n_s23;
			bad_s24 <= bad_s23;
		end
	end

	// ---- s25: X partial products, Y term sums
	logic signed [38:0] xh_w;
	logic signed [41:0] xl_w;
	logic signed [59:0] y1_w, y2_w, y3_w;
	logic signed [38:0] xh_s25;
	logic signed [41:0] xl_s25;
	logic signed [59:0] y1_s25, y2_s25, y3_s25;
	logic               bad_s25;

	assign xh_w = $signed(sx_s24[37:20]) * $signed({1'b0, n_s24});
	assign xl_w = $signed({1'b0, sx_s24[19:0]}) * $signed({1'b0, n_s24});
	assign y1_w = (60'(y1h_s24) <<< 16) + 60'(y1l_s24);
	assign y2_w = (60'(y2h_s24) <<< 20) + 60'(y2l_s24);
	assign y3_w = (60'(y3h_s24) <<< 20) + 60'(y3l_s24);

	always_ff @(posedge clk) begin
		if (adv) begin
			xh_s25  <= xh_w;
			xl_s25  <= xl_w;
			y1_s25  <= y1_w;
			y2_s25  <= y2_w;
			y3_s25  <= y3_w;
			bad_s25 <= bad_s24;
		end
	end

	// ---- s26: tilt components scaled by N^2*256
	logic signed [59:0] x_s26, y_s26;
	logic               bad_s26;

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s26   <= (60'(xh_s25) <<< 20) + 60'(xl_s25);
			y_s26   <= (y1_s25 <<< 8) + y2_s25 - (y3_s25 <<< 4);
			bad_s26 <= bad_s25;
		end
	end

	// ---- s27: magnitudes, octant flags
	logic [59:0] ux_w, uy_w;
	logic [59:0] big_s27, small_s27;
	flg_t        flg_s27;

	assign ux_w = x_s26[59] ? 60'(-x_s26) : 60'(x_s26);
	assign uy_w = y_s26[59] ? 60'(-y_s26) : 60'(y_s26);

	always_ff @(posedge clk) begin
		if (adv) begin
			big_s27        <= (ux_w >= uy_w) ? ux_w : uy_w;
			small_s27      <= (ux_w >= uy_w) ? uy_w : ux_w;
			flg_s27.bad    <= bad_s26 || (x_s26 == '0 && y_s26 == '0);
			flg_s27.swp    <= (uy_w > ux_w);
			flg_s27.xneg   <= x_s26[59];
			flg_s27.ypos   <= !y_s26[59] && (y_s26 != '0);
			flg_s27.small0 <= ((ux_w >= uy_w) ? uy_w : ux_w) == '0;
		end
	end

	// ---- s28: leading one of the larger magnitude
	logic [5:0]  pos_w;
	logic [5:0]  pos_s28;
	logic [59:0] big_s28, small_s28;
	flg_t        flg_s28;

	always_comb begin
		pos_w = 6'd0;
		for (int i = 0; i < 60; i++) begin
			if (big_s27[i]) pos_w = 6'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s28   <= pos_w;
			big_s28   <= big_s27;
			small_s28 <= small_s27;
			flg_s28   <= flg_s27;
		end
	end

	// ---- s29: shift pair so the larger lies in 2^29..2^30-1
	logic [59:0]        bsh_w, ssh_w;
	logic signed [32:0] x_s29, y_s29;
	flg_t               flg_s29;

	always_comb begin
		if (pos_s28 > 6'd29) begin
			bsh_w = big_s28 >> (pos_s28 - 6'd29);
			ssh_w = small_s28 >> (pos_s28 - 6'd29);
		end else begin
			bsh_w = big_s28 << (6'd29 - pos_s28);
			ssh_w = small_s28 << (6'd29 - pos_s28);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s29   <= $signed({2'b00, bsh_w[30:0]});
			y_s29   <= $signed({2'b00, ssh_w[30:0]});
			flg_s29 <= flg_s28;
		end
	end

	// ---- s30..s49: CORDIC vectoring, one rotation per stage
	logic signed [32:0] cx_s [0:tcch_pkg::CORDIC_STEPS-1];
	logic signed [32:0] cy_s [0:tcch_pkg::CORDIC_STEPS-1];
	logic signed [25:0] cz_s [0:tcch_pkg::CORDIC_STEPS-1];
	flg_t               cf_s [0:tcch_pkg::CORDIC_STEPS-1];

	for (genvar g = 0; g < tcch_pkg::CORDIC_STEPS; g++) begin : g_cor
		logic signed [32:0] x_in, y_in, dx, dy;
		logic signed [25:0] z_in, at;
		flg_t               f_in;
		if (g == 0) begin : g_src0
			assign x_in = x_s29;
			assign y_in = y_s29;
			assign z_in = '0;
			assign f_in = flg_s29;
		end else begin : g_srcn
			assign x_in = cx_s[g-1];
			assign y_in = cy_s[g-1];
			assign z_in = cz_s[g-1];
			assign f_in = cf_s[g-1];
		end
		assign dx = y_in >>> g;
		assign dy = x_in >>> g;
		assign at = tcch_pkg::atan_lut(5'(g));
		always_ff @(posedge clk) begin
			if (adv) begin
				cf_s[g] <= f_in;
				if (!y_in[32]) begin
					cx_s[g] <= x_in + dx;
					cy_s[g] <= y_in - dy;
					cz_s[g] <= z_in + at;
				end else begin
					cx_s[g] <= x_in - dx;
					cy_s[g] <= y_in + dy;
					cz_s[g] <= z_in - at;
				end
			end
		end
	end

	// ---- s50: place angle by octant and signs, clamp to one turn
	flg_t               fl_e;
	logic signed [26:0] phi_w, alpha_w, theta_w, h_w;
	logic [24:0]        h_s50;
	logic               bad_s50;

	assign fl_e = cf_s[tcch_pkg::CORDIC_STEPS-1];

	always_comb begin
		phi_w   = fl_e.small0 ? 27'sd0 : 27'(cz_s[tcch_pkg::CORDIC_STEPS-1]);
		alpha_w = fl_e.swp ? (tcch_pkg::QUARTER_TURN - phi_w) : phi_w;
		theta_w = fl_e.xneg ? (tcch_pkg::HALF_TURN - alpha_w) : alpha_w;
		h_w     = fl_e.ypos ? theta_w : (tcch_pkg::FULL_TURN - theta_w);
		if (h_w < 27'sd0) h_w = 27'sd0;
		if (h_w > tcch_pkg::FULL_TURN) h_w = tcch_pkg::FULL_TURN;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			h_s50   <= h_w[24:0];
			bad_s50 <= fl_e.bad;
		end
	end

	// ---- output register: round to 1/16 degree, add offset, wrap once
	logic [25:0] hr_w;
	logic [14:0] sum_w, wrap_w;
	logic [12:0] hd_q;
	logic        inv_q;

	assign hr_w   = {1'b0, h_s50} + 26'd2048;
	assign sum_w  = {1'b0, hr_w[25:12]} + {2'b00, offset};
	assign wrap_w = (sum_w > tcch_pkg::TURN_16THS) ? (sum_w - tcch_pkg::TURN_16THS) : sum_w;

	always_ff @(posedge clk) begin
		if (adv) begin
			hd_q  <= bad_s50 ? 13'd0 : wrap_w[12:0];
			inv_q <= bad_s50;
		end
	end

	assign m_heading = hd_q;
	assign m_invalid = inv_q;

endmodule

`default_nettype wire

// File: rtl/core/tilt_compensated_compass_heading_top.sv
// ----------------------------------------------------------------------------
// tilt_compensated_compass_heading_top: tilt-compensated compass heading
// Accel + mag vector in, heading in 1/16 degree plus invalid flag out.
// ----------------------------------------------------------------------------
// Path: a beat is written into the queue, then passes 50 datapath stages
//   and one output register before m_tvalid rises.
// Throughput: one beat per cycle; the datapath is fully pipelined, the
//   pipeline holds only while the output beat is not taken.
// Reset: arst_n clears the queue, all stage valids and the output valid;
//   declination offset returns to 176 (11 degrees). No clearing pass.
`default_nettype none

module tilt_compensated_compass_heading_top (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // accel_x, accel_y, accel_z, mag_x, mag_y, mag_z
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // heading[12:0], zero pad
	output logic        m_tuser,   // invalid
	// declination offset register
	input  logic        cfg_wen,
	input  logic [12:0] cfg_wdata
);

	tcch_pkg::item_t raw, cls, q_item;
	logic            full, nonempty, pop, push;
	logic [12:0]     offset_q;
	logic [12:0]     heading;

	// Declination offset; the user writes it only while idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= tcch_pkg::OFFSET_RESET;
		end else if (cfg_wen) begin
			offset_q <= cfg_wdata;
		end
	end

	// Unpack the input beat; first field in the low bits.
	always_comb begin
		raw     = '0;
		raw.ax  = s_tdata[15:0];
		raw.ay  = s_tdata[31:16];
		raw.az  = s_tdata[47:32];
		raw.mx  = s_tdata[63:48];
		raw.my  = s_tdata[79:64];
		raw.mz  = s_tdata[95:80];
	end

	// Front: zero-accel detect and accel range scaling.
	tcch_front u_front (
		.raw (raw),
		.cls (cls)
	);

	// Queue decouples the input side from datapath stalls.
	assign s_tready = !full;
	assign push     = s_tvalid && !full;

	tcch_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (cls),
		.full     (full),
		.pop      (pop),
		.nonempty (nonempty),
		.rdata    (q_item)
	);

	// Back: roots, tilt products, CORDIC, output register.
	tcch_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (nonempty),
		.in_item   (q_item),
		.in_pop    (pop),
		.offset    (offset_q),
		.m_valid   (m_tvalid),
		.m_ready   (m_tready),
		.m_heading (heading),
		.m_invalid (m_tuser)
	);

	assign m_tdata = {3'b000, heading};

endmodule

`default_nettype wire

// File: tb/tilt_compensated_compass_heading_top_test.sv
// ----------------------------------------------------------------------------
// tilt_compensated_compass_heading_top_test: heading block testbench
// Drives accel/mag beats with random gaps, predicts each heading with an
// integer model of the tilt/CORDIC math, checks results in order.
// ----------------------------------------------------------------------------
`default_nettype none

class heading_board;
	logic [12:0] decl;
	logic [12:0] want_heading[$];
	logic        want_invalid[$];
	int          errors;

	function new();
		decl = tcch_pkg::OFFSET_RESET;
		errors = 0;
	endfunction

	static function longint unsigned root(longint unsigned v);
		longint unsigned res, bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > v) bit_v >>= 2;
		while (bit_v != 0) begin
			if (v >= res + bit_v) begin
				v -= res + bit_v;
				res = (res >> 1) + bit_v;
			end else begin
				res >>= 1;
			end
			bit_v >>= 2;
		end
		return res;
	endfunction

	static function longint unsigned absv(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	// atan(lo/hi) in 1/65536 degree
	static function longint arctan(longint unsigned hi, longint unsigned lo);
		longint x, y, z, dx, dy;
		z = 0;
		while (hi >= (64'd1 << 30)) begin
			hi >>= 1;
			lo >>= 1;
		end
		while (hi < (64'd1 << 29)) begin
			hi <<= 1;
			lo <<= 1;
		end
		x = hi;
		y = lo;
		for (int i = 0; i < tcch_pkg::CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx;
				y -= dy;
				z += tcch_pkg::atan_lut(i[4:0]);
			end else begin
				x -= dx;
				y += dy;
				z -= tcch_pkg::atan_lut(i[4:0]);
			end
		end
		return z;
	endfunction

	function void note_vector(logic [95:0] d);
		longint ax, ay, az, mx, my, mz, sc, tx, ty, phi, alpha, theta, h;
		longint unsigned amax, qp, qr, n, ux, uy, big, lo, r, sum;
		ax = longint'($signed(d[15:0]));
		ay = longint'($signed(d[31:16]));
		az = longint'($signed(d[47:32]));
		mx = longint'($signed(d[63:48]));
		my = longint'($signed(d[79:64]));
		mz = longint'($signed(d[95:80]));
		amax = absv(ax);
		if (absv(ay) > amax) amax = absv(ay);
		if (absv(az) > amax) amax = absv(az);
		if (amax == 0) begin
			want_heading.push_back(0);
			want_invalid.push_back(1);
			return;
		end
		sc = 1;
		while (amax < 16384) begin
			amax <<= 1;
			sc *= 2;
		end
		ax *= sc;
		ay *= sc;
		az *= sc;
		qp = root((ay * ay + az * az) << 8);
		qr = root((ax * ax + az * az) << 8);
		n = root((ax * ax + ay * ay + az * az) << 8);
		tx = longint'(n) * (mx * longint'(qp) + mz * ax * 16);
		ty = mx * ay * ax * 256 + my * longint'(qr) * longint'(n) - mz * ay * longint'(qp) * 16;
		if (tx == 0 && ty == 0) begin
			want_heading.push_back(0);
			want_invalid.push_back(1);
			return;
		end
		ux = absv(tx);
		uy = absv(ty);
		big = ux >= uy ? ux : uy;
		lo = ux >= uy ? uy : ux;
		phi = (lo == 0) ? 0 : arctan(big, lo);
		alpha = (uy <= ux) ? phi : longint'(tcch_pkg::QUARTER_TURN) - phi;
		theta = (tx >= 0) ? alpha : longint'(tcch_pkg::HALF_TURN) - alpha;
		h = (ty > 0) ? theta : longint'(tcch_pkg::FULL_TURN) - theta;
		if (h < 0) h = 0;
		if (h > tcch_pkg::FULL_TURN) h = tcch_pkg::FULL_TURN;
		r = (h + 2048) >> 12;
		sum = r + decl;
		if (sum > tcch_pkg::TURN_16THS) sum -= tcch_pkg::TURN_16THS;
		want_heading.push_back(sum[12:0]);
		want_invalid.push_back(1'b0);
	endfunction

	function void check_heading(logic [15:0] d, logic inv);
		logic [12:0] eh;
		logic        ei;
		if (want_heading.size() == 0) begin
			$error("unexpected beat: heading %0d invalid %0d", d[12:0], inv);
			errors++;
			return;
		end
		eh = want_heading.pop_front();
		ei = want_invalid.pop_front();
		if (d[12:0] !== eh) begin
			$error("heading: expected %0d, got %0d", eh, d[12:0]);
			errors++;
		end
		if (d[15:13] !== 3'b0) begin
			$error("pad: expected 0, got %0d", d[15:13]);
			errors++;
		end
		if (inv !== ei) begin
			$error("invalid: expected %0d, got %0d", ei, inv);
			errors++;
		end
	endfunction
endclass

module tilt_compensated_compass_heading_top_test;

	localparam int WATCHDOG = 20000;
	localparam int N_RANDOM = 1860;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;   // accel_x, accel_y, accel_z, mag_x, mag_y, mag_z
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [15:0] m_tdata;        // heading[12:0], zero pad
	logic        m_tuser;        // invalid
	logic        cfg_wen = 0;
	logic [12:0] cfg_wdata = '0;

	heading_board board = new();
	int  idle_cycles = 0;
	bit  hold_sink = 0;   // forces a long receiver stall
	bit  timed_out = 0;

	tilt_compensated_compass_heading_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	// Score at the rising edge; both sides handshake here.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) board.note_vector(s_tdata);
			if (m_tvalid && m_tready) board.check_heading(m_tdata, m_tuser);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
		end
	end

	// Watchdog on cycles with no beat moving.
	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG && !timed_out) begin
			timed_out = 1;
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Receiver: random stall per beat, long hold-off on request.
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_sink) begin
				m_tready <= 0;
			end else begin
				w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
				if (w > 0) begin
					m_tready <= 0;
					repeat (w) @(negedge clk);
				end
				m_tready <= 1;
				do @(posedge clk); while (!(m_tvalid && m_tready) && !hold_sink);
			end
		end
	end

	task automatic send_vector(input logic [95:0] d, input int gap);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	function automatic logic [95:0] pack(input logic [15:0] ax, ay, az, mx, my, mz);
		return {mz, my, mx, az, ay, ax};
	endfunction

	function automatic logic [15:0] rnd_axis();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($signed($urandom_range(0, 8)) - 4);
			3: return 16'($signed($urandom_range(0, 400)) - 200);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int rnd_gap();
		return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
	endfunction

	// Offset writes only when nothing is in flight.
	task automatic write_decl(input logic [12:0] v);
		s_tvalid <= 0;
		while (board.want_heading.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		cfg_wen <= 1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_wen <= 0;
		board.decl = v;
	endtask

	initial begin
		logic [12:0] decls[5];
		int per_phase;
		decls = '{13'd0, 13'd5759, 13'd8191, 13'd2880, 13'd4321};
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: zero accel, zero tilt with mag along +X/-X/+Y/-Y, extremes, a small tilt.
		send_vector(pack(0, 0, 0, 100, 200, 300), 0);
		send_vector(pack(0, 0, 16384, 0, 0, 0), 0);
		send_vector(pack(0, 0, 16384, 1000, 0, 0), 0);
		send_vector(pack(0, 0, 16384, -1000, 0, 0), 0);
		send_vector(pack(0, 0, 16384, 0, 1000, 0), 0);
		send_vector(pack(0, 0, 16384, 0, -1000, 0), 0);
		send_vector(pack(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000), 1);
		send_vector(pack(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff), 0);
		send_vector(pack(16'h7fff, 16'h8000, 1, 16'h8000, 16'h7fff, -1), 2);
		send_vector(pack(1, 0, 0, 0, 0, 5), 0);
		send_vector(pack(0, -1, 0, 7, -3, 0), 0);
		send_vector(pack(0, 0, 16384, -1000, -1, 0), 0);
		send_vector(pack(0, 0, 16384, -1000, 1, 0), 0);
		send_vector(pack(300, -400, 16000, 1200, -800, 400), 0);

		// Long receiver stall while the sender keeps offering beats.
		fork
			begin
				hold_sink = 1;
				repeat (150) @(posedge clk);
				hold_sink = 0;
			end
			for (int i = 0; i < 80; i++)
				send_vector(pack(rnd_axis(), rnd_axis(), rnd_axis(),
					rnd_axis(), rnd_axis(), rnd_axis()), 0);
		join

		per_phase = N_RANDOM / 6;
		for (int p = 0; p < 6; p++) begin
			if (p > 0) write_decl(decls[p - 1]);
			for (int i = 0; i < per_phase; i++)
				send_vector(pack(rnd_axis(), rnd_axis(), rnd_axis(),
					rnd_axis(), rnd_axis(), rnd_axis()),
					(p % 2 == 0 && i < 40) ? 0 : rnd_gap());
		end
		s_tvalid <= 0;

		while (board.want_heading.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (board.errors == 0 && board.want_heading.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

`default_nettype wire

// File: tilt_compensated_compass_heading_top.f
rtl/core/tcch_pkg.sv
rtl/core/tcch_front.sv
rtl/core/tcch_fifo.sv
rtl/core/tcch_back.sv
rtl/core/tilt_compensated_compass_heading_top.sv
tb/tilt_compensated_compass_heading_top_test.sv
